// File: rtl/core/zbc_pkg.sv
// zbc_pkg: shared constants, status codes and fixed-point helpers for the
// zero moment point balance controller. No dependencies.
package zbc_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int ZMP_BITS   = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 192;
  localparam int CFG_ADDR_W = 5;

  // Register indexes
  localparam logic [2:0] REG_SENSOR_HEIGHT = 3'd0;
  localparam logic [2:0] REG_EMA_ALPHA     = 3'd1;
  localparam logic [2:0] REG_ANGLE_GAIN    = 3'd2;
  localparam logic [2:0] REG_ANGLE_LIMIT   = 3'd3;
  localparam logic [2:0] REG_SHIFT_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TARGET_OFFSET = 3'd5;
  localparam logic [2:0] REG_SAMPLE_LIMIT  = 3'd6;

  // Register reset values
  localparam logic [23:0] RST_SENSOR_HEIGHT = 24'd419430;
  localparam logic [15:0] RST_EMA_ALPHA     = 16'd45875;
  localparam logic [23:0] RST_ANGLE_GAIN    = 24'd468276;
  localparam logic [29:0] RST_ANGLE_LIMIT   = 30'd1123850;
  localparam logic [29:0] RST_SHIFT_LIMIT   = 30'd2147484;
  localparam logic [23:0] RST_TARGET_OFFSET = 24'd503316;
  localparam logic [15:0] RST_SAMPLE_LIMIT  = 16'd500;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SKIP = 2'd1;
  localparam logic [1:0] STATUS_DONE = 2'd2;

  localparam logic [32:0] SHIFT_DIVISOR = 33'd100;
  localparam logic [63:0] SHIFT_HALF    = 64'd50;

  localparam logic signed [65:0] ZMP_MAX = 66'sd2 ** (ZMP_BITS - 1) - 66'sd1;
  localparam logic signed [65:0] ZMP_MIN = -ZMP_MAX - 66'sd1;

  // Magnitude of a signed 64-bit value
  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // Saturate to the zmp word
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > ZMP_MAX) r = ZMP_MAX;
    if (v < ZMP_MIN) r = ZMP_MIN;
    return r[31:0];
  endfunction

  // Saturate a truncated quotient magnitude with its sign
  function automatic logic signed [31:0] qsat(input logic [63:0] q, input logic neg);
    logic signed [65:0] v;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    return sat66(v);
  endfunction

  // Divide by 2^s, round half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] x,
                                                   input int s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = abs64(x);
    r   = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  // Symmetric clamp to +/- lim
  function automatic logic signed [31:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic [29:0] lim);
    logic signed [63:0] l;
    logic signed [63:0] r;
    l = $signed({34'd0, lim});
    r = v;
    if (v >= l) r = l;
    else if (v <= -l) r = -l;
    return r[31:0];
  endfunction

endpackage

// File: rtl/core/zmp_balance_controller_top.sv
// zmp_balance_controller_top: zero moment point estimate, smoothing and
// clamped balance steps. Depends on zbc_pkg.
//
// Usage: one force/torque request enters on the in_ stream (tdata from bit 0:
// force_x, force_y, force_z, torque_y, torque_z, leg_negative). One result
// leaves on the out_ stream per request (tuser = status, tdata from bit 0:
// angle_step, shift_step, zmp_lateral, zmp_forward, target_lateral,
// target_forward). Registers sit on the APB-style cfg_ port at 4*index.
// A skipped or done request goes from accept to the ST_OUT state, and its result
// is loaded into the output register once that register is free. A control
// request runs in sequence on one shared shift-add multiplier, one restoring
// divider and a 2-bit-per-cycle square root; the first sample that fixes the
// target also runs the norm products, the square root and, unless the norm is
// zero, two target divisions.
// One request is in work at a time; in_tready is high while the sequencer
// is idle, and a result waiting in the output register does not block it.
// If the receiver stalls, the finished result of the next request waits in
// the sequencer until the output register is free.
// Reset (synchronous, rst_n low) clears the filter, the target, the sample
// count and the output register and restores register defaults.
module zmp_balance_controller_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // force_x, force_y, force_z, torque_y, torque_z, leg_negative, zero pad
  input  logic [zbc_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // angle_step, shift_step, zmp_lateral, zmp_forward, target_lateral,
  // target_forward
  output logic [zbc_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [zbc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // Sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RUN  = 5'd1;
  localparam logic [4:0] ST_OUT  = 5'd2;
  localparam logic [4:0] ST_P0   = 5'd3;
  localparam logic [4:0] ST_P1   = 5'd4;
  localparam logic [4:0] ST_P2   = 5'd5;
  localparam logic [4:0] ST_P3   = 5'd6;
  localparam logic [4:0] ST_P4   = 5'd7;
  localparam logic [4:0] ST_P5   = 5'd8;
  localparam logic [4:0] ST_P6   = 5'd9;
  localparam logic [4:0] ST_P7   = 5'd10;
  localparam logic [4:0] ST_P8   = 5'd11;
  localparam logic [4:0] ST_P9   = 5'd12;
  localparam logic [4:0] ST_P10  = 5'd13;
  localparam logic [4:0] ST_P11  = 5'd14;
  localparam logic [4:0] ST_P12  = 5'd15;
  localparam logic [4:0] ST_P13  = 5'd16;
  localparam logic [4:0] ST_P14  = 5'd17;
  localparam logic [4:0] ST_P15  = 5'd18;
  localparam logic [4:0] ST_P16  = 5'd19;
  localparam logic [4:0] ST_P17  = 5'd20;
  localparam logic [4:0] ST_P18  = 5'd21;

  // Arithmetic unit select
  localparam logic [1:0] U_MUL  = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_SQRT = 2'd2;

  localparam logic [5:0] MUL_CYC  = 6'd31;
  localparam logic [5:0] DIV_CYC  = 6'd63;
  localparam logic [5:0] SQRT_CYC = 6'd31;

  // Configuration registers
  logic [23:0] sensor_height_r;
  logic [15:0] ema_alpha_r;
  logic [23:0] angle_gain_r;
  logic [29:0] angle_limit_r;
  logic [29:0] shift_limit_r;
  logic [23:0] target_offset_r;
  logic [15:0] sample_limit_r;

  // Request and state registers
  logic [4:0]         st_r, ret_r;
  logic signed [31:0] fx_r, fy_r, fz_r, ty_r, tz_r;
  logic               leg_r, neg_r;
  logic signed [31:0] raw_fwd_r, raw_lat_r;
  logic signed [31:0] filt_lat_r, filt_fwd_r, goal_lat_r, goal_fwd_r;
  logic               goal_fixed_r;
  logic [15:0]        seen_r;
  logic signed [31:0] angle_r, shift_r;
  logic [1:0]         status_r;

  // Serial arithmetic registers
  logic [1:0]         unit_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] mc_r, prod_r;
  logic [31:0]        mb_r;
  logic [63:0]        dd_r;
  logic [32:0]        dv_r, rem_r;
  logic [63:0]        sq_r;
  logic [33:0]        srem_r;
  logic [31:0]        root_r;

  // Output register
  logic                        out_tvalid_r;
  logic [zbc_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]                  out_tuser_r;

  logic cfg_wr;
  logic in_acc;

  // Launch request for the arithmetic unit
  logic               l_go, l_clr;
  logic [1:0]         l_unit;
  logic [4:0]         l_ret;
  logic signed [63:0] l_a;
  logic [63:0]        l_b;

  // Datapath helpers
  logic signed [63:0] fx_ext, ty_sh, tz_sh, num_fwd, num_lat;
  logic signed [63:0] flat_ext, ffwd_ext, err_lat, err_fwd, shift_x, angle_p;
  logic [33:0]        div_t, div_v;
  logic [35:0]        sqrt_t, sqrt_v;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_tready  = (st_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Register read-back
  always_comb begin
    case (cfg_paddr[4:2])
      zbc_pkg::REG_SENSOR_HEIGHT: cfg_prdata = {8'd0, sensor_height_r};
      zbc_pkg::REG_EMA_ALPHA:     cfg_prdata = {16'd0, ema_alpha_r};
      zbc_pkg::REG_ANGLE_GAIN:    cfg_prdata = {8'd0, angle_gain_r};
      zbc_pkg::REG_ANGLE_LIMIT:   cfg_prdata = {2'd0, angle_limit_r};
      zbc_pkg::REG_SHIFT_LIMIT:   cfg_prdata = {2'd0, shift_limit_r};
      zbc_pkg::REG_TARGET_OFFSET: cfg_prdata = {8'd0, target_offset_r};
      zbc_pkg::REG_SAMPLE_LIMIT:  cfg_prdata = {16'd0, sample_limit_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Derived operands
  assign fx_ext   = 64'(fx_r);
  assign ty_sh    = $signed({{8{ty_r[31]}}, ty_r, 24'd0});
  assign tz_sh    = $signed({{8{tz_r[31]}}, tz_r, 24'd0});
  assign num_fwd  = ty_sh + prod_r;
  assign num_lat  = prod_r - tz_sh;
  assign flat_ext = 64'(filt_lat_r);
  assign ffwd_ext = 64'(filt_fwd_r);
  assign err_lat  = 64'(goal_lat_r) - flat_ext;
  assign err_fwd  = 64'(goal_fwd_r) - ffwd_ext;
  assign shift_x  = -(err_fwd <<< 6);
  assign angle_p  = leg_r ? prod_r : -prod_r;

  // Digit step terms
  assign div_t  = {rem_r, dd_r[63]};
  assign div_v  = {1'b0, dv_r};
  assign sqrt_t = {srem_r, sq_r[63:62]};
  assign sqrt_v = {2'b00, root_r, 2'b01};

  // Operation launched by each sequencer step
  always_comb begin
    l_go   = 1'b0;
    l_clr  = 1'b1;
    l_unit = U_MUL;
    l_ret  = ST_IDLE;
    l_a    = '0;
    l_b    = '0;
    case (st_r)
      ST_P0: begin
        l_go = 1'b1; l_ret = ST_P1;
        l_a = 64'(fz_r); l_b = {40'd0, sensor_height_r};
      end
      ST_P1: begin
        l_go = 1'b1; l_ret = ST_P2; l_unit = U_DIV;
        l_a = $signed(zbc_pkg::abs64(num_fwd)); l_b = zbc_pkg::abs64(fx_ext);
      end
      ST_P2: begin
        l_go = 1'b1; l_ret = ST_P3;
        l_a = 64'(fy_r); l_b = {40'd0, sensor_height_r};
      end
      ST_P3: begin
        l_go = 1'b1; l_ret = ST_P4; l_unit = U_DIV;
        l_a = $signed(zbc_pkg::abs64(num_lat)); l_b = zbc_pkg::abs64(fx_ext);
      end
      ST_P4: begin
        l_go = 1'b1; l_ret = ST_P5;
        l_a = 64'(zbc_pkg::qsat(dd_r, neg_r)); l_b = {48'd0, ema_alpha_r};
      end
      ST_P5: begin
        l_go = 1'b1; l_ret = ST_P6; l_clr = 1'b0;
        l_a = flat_ext; l_b = 64'(17'h10000 - {1'b0, ema_alpha_r});
      end
      ST_P6: begin
        l_go = 1'b1; l_ret = ST_P7;
        l_a = 64'(raw_fwd_r); l_b = {48'd0, ema_alpha_r};
      end
      ST_P7: begin
        l_go = 1'b1; l_ret = ST_P8; l_clr = 1'b0;
        l_a = ffwd_ext; l_b = 64'(17'h10000 - {1'b0, ema_alpha_r});
      end
      ST_P8: begin
        l_go = ~goal_fixed_r; l_ret = ST_P9;
        l_a = $signed(zbc_pkg::abs64(flat_ext)); l_b = zbc_pkg::abs64(flat_ext);
      end
      ST_P9: begin
        l_go = 1'b1; l_ret = ST_P10; l_clr = 1'b0;
        l_a = $signed(zbc_pkg::abs64(ffwd_ext)); l_b = zbc_pkg::abs64(ffwd_ext);
      end
      ST_P10: begin
        l_go = 1'b1; l_ret = ST_P11; l_unit = U_SQRT;
        l_a = prod_r;
      end
      ST_P11: begin
        l_go = (root_r != 32'd0); l_ret = ST_P12;
        l_a = flat_ext; l_b = {40'd0, target_offset_r};
      end
      ST_P12: begin
        l_go = 1'b1; l_ret = ST_P13; l_unit = U_DIV;
        l_a = $signed(zbc_pkg::abs64(prod_r)); l_b = {32'd0, root_r};
      end
      ST_P13: begin
        l_go = 1'b1; l_ret = ST_P14;
        l_a = ffwd_ext; l_b = {40'd0, target_offset_r};
      end
      ST_P14: begin
        l_go = 1'b1; l_ret = ST_P15; l_unit = U_DIV;
        l_a = $signed(zbc_pkg::abs64(prod_r)); l_b = {32'd0, root_r};
      end
      ST_P16: begin
        l_go = 1'b1; l_ret = ST_P17;
        l_a = err_lat; l_b = {40'd0, angle_gain_r};
      end
      ST_P17: begin
        l_go = 1'b1; l_ret = ST_P18; l_unit = U_DIV;
        l_a = $signed(zbc_pkg::abs64(shift_x) + zbc_pkg::SHIFT_HALF);
        l_b = {31'd0, zbc_pkg::SHIFT_DIVISOR};
      end
      default: l_go = 1'b0;
    endcase
  end

  // Sequencer, serial units and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_height_r <= zbc_pkg::RST_SENSOR_HEIGHT;
      ema_alpha_r     <= zbc_pkg::RST_EMA_ALPHA;
      angle_gain_r    <= zbc_pkg::RST_ANGLE_GAIN;
      angle_limit_r   <= zbc_pkg::RST_ANGLE_LIMIT;
      shift_limit_r   <= zbc_pkg::RST_SHIFT_LIMIT;
      target_offset_r <= zbc_pkg::RST_TARGET_OFFSET;
      sample_limit_r  <= zbc_pkg::RST_SAMPLE_LIMIT;
      st_r            <= ST_IDLE;
      filt_lat_r      <= '0;
      filt_fwd_r      <= '0;
      goal_lat_r      <= '0;
      goal_fwd_r      <= '0;
      goal_fixed_r    <= 1'b0;
      seen_r          <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      // Register writes
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          zbc_pkg::REG_SENSOR_HEIGHT: sensor_height_r <= cfg_pwdata[23:0];
          zbc_pkg::REG_EMA_ALPHA:     ema_alpha_r     <= cfg_pwdata[15:0];
          zbc_pkg::REG_ANGLE_GAIN:    angle_gain_r    <= cfg_pwdata[23:0];
          zbc_pkg::REG_ANGLE_LIMIT:   angle_limit_r   <= cfg_pwdata[29:0];
          zbc_pkg::REG_SHIFT_LIMIT:   shift_limit_r   <= cfg_pwdata[29:0];
          zbc_pkg::REG_TARGET_OFFSET: target_offset_r <= cfg_pwdata[23:0];
          zbc_pkg::REG_SAMPLE_LIMIT:  sample_limit_r  <= cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // Output drain, unless a new result is loaded in the same cycle
      if (out_tvalid_r && out_tready && st_r != ST_OUT) out_tvalid_r <= 1'b0;

      // Launch a serial operation
      if (l_go) begin
        st_r   <= ST_RUN;
        ret_r  <= l_ret;
        unit_r <= l_unit;
        case (l_unit)
          U_MUL: begin
            cnt_r <= MUL_CYC;
            mc_r  <= l_a;
            mb_r  <= l_b[31:0];
            if (l_clr) prod_r <= '0;
          end
          U_DIV: begin
            cnt_r <= DIV_CYC;
            dd_r  <= l_a;
            dv_r  <= l_b[32:0];
            rem_r <= '0;
          end
          default: begin
            cnt_r  <= SQRT_CYC;
            sq_r   <= l_a;
            srem_r <= '0;
            root_r <= '0;
          end
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            fx_r    <= in_tdata[31:0];
            fy_r    <= in_tdata[63:32];
            fz_r    <= in_tdata[95:64];
            ty_r    <= in_tdata[127:96];
            tz_r    <= in_tdata[159:128];
            leg_r   <= in_tdata[160];
            angle_r <= '0;
            shift_r <= '0;
            if (seen_r >= sample_limit_r) begin
              status_r <= zbc_pkg::STATUS_DONE;
              st_r     <= ST_OUT;
            end else if (in_tdata[31:0] == 32'd0) begin
              status_r <= zbc_pkg::STATUS_SKIP;
              st_r     <= ST_OUT;
            end else begin
              status_r <= zbc_pkg::STATUS_OK;
              st_r     <= ST_P0;
            end
          end
        end
        // One digit per cycle on the selected unit
        ST_RUN: begin
          case (unit_r)
            U_MUL: begin
              if (mb_r[0]) prod_r <= prod_r + mc_r;
              mc_r <= mc_r <<< 1;
              mb_r <= mb_r >> 1;
            end
            U_DIV: begin
              if (div_t >= div_v) begin
                rem_r <= 33'(div_t - div_v);
                dd_r  <= {dd_r[62:0], 1'b1};
              end else begin
                rem_r <= div_t[32:0];
                dd_r  <= {dd_r[62:0], 1'b0};
              end
            end
            default: begin
              if (sqrt_t >= sqrt_v) begin
                srem_r <= 34'(sqrt_t - sqrt_v);
                root_r <= {root_r[30:0], 1'b1};
              end else begin
                srem_r <= sqrt_t[33:0];
                root_r <= {root_r[30:0], 1'b0};
              end
              sq_r <= sq_r << 2;
            end
          endcase
          if (cnt_r == 6'd0) st_r <= ret_r;
          else cnt_r <= cnt_r - 6'd1;
        end
        // Result waits for a free output register
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= status_r;
            out_tdata_r  <= {goal_fwd_r, goal_lat_r, filt_fwd_r, filt_lat_r,
                             shift_r, angle_r};
            st_r         <= ST_IDLE;
          end
        end
        ST_P1: neg_r <= num_fwd[63] ^ fx_r[31];
        ST_P2: raw_fwd_r <= zbc_pkg::qsat(dd_r, neg_r);
        ST_P3: neg_r <= num_lat[63] ^ fx_r[31];
        ST_P4: raw_lat_r <= zbc_pkg::qsat(dd_r, neg_r);
        ST_P6: filt_lat_r <= zbc_pkg::sat66(66'(zbc_pkg::shr_round(prod_r, 16)));
        ST_P8: begin
          filt_fwd_r <= zbc_pkg::sat66(66'(zbc_pkg::shr_round(prod_r, 16)));
          if (goal_fixed_r) st_r <= ST_P16;
        end
        ST_P11: begin
          if (root_r == 32'd0) begin
            goal_lat_r   <= filt_lat_r;
            goal_fwd_r   <= filt_fwd_r;
            goal_fixed_r <= 1'b1;
            st_r         <= ST_P16;
          end
        end
        ST_P12: neg_r <= prod_r[63];
        ST_P13: goal_lat_r <= zbc_pkg::sat66(66'(filt_lat_r) -
                                              66'(zbc_pkg::qsat(dd_r, neg_r)));
        ST_P14: neg_r <= prod_r[63];
        ST_P15: begin
          goal_fwd_r   <= zbc_pkg::sat66(66'(filt_fwd_r) -
                                         66'(zbc_pkg::qsat(dd_r, neg_r)));
          goal_fixed_r <= 1'b1;
          st_r         <= ST_P16;
        end
        ST_P17: begin
          angle_r <= zbc_pkg::clamp_sym(zbc_pkg::shr_round(angle_p, 18), angle_limit_r);
          neg_r   <= shift_x[63];
        end
        ST_P18: begin
          shift_r <= zbc_pkg::clamp_sym(neg_r ? -$signed(dd_r) : $signed(dd_r),
                                        shift_limit_r);
          seen_r  <= seen_r + 16'd1;
          st_r    <= ST_OUT;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/zbc_checker.sv
// zbc_checker: port-level checks on the balance controller, bound to
// zmp_balance_controller_top. Depends on zbc_pkg.
module zbc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [zbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Steps are zero unless a control result
  a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != zbc_pkg::STATUS_OK |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero step on skipped or done result");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

endmodule

bind zmp_balance_controller_top zbc_checker u_zbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: verif/zmp_balance_controller_top_tb.sv
// Testbench for zmp_balance_controller_top: drives force/torque requests on the
// in_ stream and checks each result against an in-bench balance predictor.
// Depends on zbc_pkg and the block's RTL.
`timescale 1ns / 100ps

module zmp_balance_controller_top_tb;
  import zbc_pkg::*;

  localparam int TIMEOUT_CYCLES = 6_000_000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] angle;
    logic signed [31:0] shift;
    logic signed [31:0] zmp_lat;
    logic signed [31:0] zmp_fwd;
    logic signed [31:0] tgt_lat;
    logic signed [31:0] tgt_fwd;
  } balance_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  zmp_balance_controller_top u_dut (.*);

  // predictor copy of registers and state
  logic [23:0] m_height, m_gain, m_offset;
  logic [15:0] m_alpha, m_window;
  logic [29:0] m_angle_lim, m_shift_lim;
  logic signed [63:0] m_flt_lat, m_flt_fwd, m_goal_lat, m_goal_fwd;
  logic m_goal_set;
  int unsigned m_seen;

  balance_result_t expected_q[$];
  int errors = 0;
  int cycle_count = 0;
  bit quiet_tail = 0;
  bit rx_idle_en = 1;

  initial begin
    forever #6 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("zmp_balance_controller_top_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    errors++;
  endtask

  function automatic logic signed [63:0] sat_zmp(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                     input int s);
    logic [63:0] mag;
    mag = x[63] ? -x : x;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] limit_sym(input logic signed [63:0] v,
                                                   input logic [29:0] lim);
    logic signed [63:0] l;
    l = {34'd0, lim};
    if (v >= l) return l;
    if (v <= -l) return -l;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] smooth(input logic signed [63:0] raw,
                                                input logic signed [63:0] prev);
    logic signed [63:0] a;
    a = {48'd0, m_alpha};
    return sat_zmp(round_shift(a * raw + (64'sd65536 - a) * prev, 16));
  endfunction

  function automatic logic signed [63:0] pull_in(input logic signed [63:0] p,
                                                 input logic [63:0] norm);
    logic signed [63:0] off;
    if (norm == 0) return p;
    off = {40'd0, m_offset};
    return sat_zmp(p - (p * off) / $signed(norm));
  endfunction

  // balance predictor: one result per request
  function automatic balance_result_t predict_step(input logic [IN_DATA_W-1:0] d);
    balance_result_t r;
    logic signed [63:0] fx, fy, fz, ty, tz, h, raw_lat, raw_fwd, e_lat, e_fwd, prod;
    logic signed [63:0] num, mag;
    logic [63:0] norm;
    r = '0;
    fx = $signed(d[31:0]);
    fy = $signed(d[63:32]);
    fz = $signed(d[95:64]);
    ty = $signed(d[127:96]);
    tz = $signed(d[159:128]);
    if (m_seen >= m_window) r.status = STATUS_DONE;
    else if (fx == 0) r.status = STATUS_SKIP;
    else begin
      h = {40'd0, m_height};
      raw_fwd = sat_zmp((ty * 64'sd16777216 + fz * h) / fx);
      raw_lat = sat_zmp((fy * h - tz * 64'sd16777216) / fx);
      m_flt_lat = smooth(raw_lat, m_flt_lat);
      m_flt_fwd = smooth(raw_fwd, m_flt_fwd);
      if (!m_goal_set) begin
        norm = floor_sqrt(m_flt_lat * m_flt_lat + m_flt_fwd * m_flt_fwd);
        m_goal_lat = pull_in(m_flt_lat, norm);
        m_goal_fwd = pull_in(m_flt_fwd, norm);
        m_goal_set = 1;
      end
      e_lat = m_goal_lat - m_flt_lat;
      e_fwd = m_goal_fwd - m_flt_fwd;
      prod = e_lat * $signed({40'd0, m_gain});
      if (!d[160]) prod = -prod;
      r.angle = 32'(limit_sym(round_shift(prod, 18), m_angle_lim));
      num = -(e_fwd * 64);
      mag = num < 0 ? -num : num;
      mag = (mag + 50) / 100;
      r.shift = 32'(limit_sym(num < 0 ? -mag : mag, m_shift_lim));
      m_seen++;
      r.status = STATUS_OK;
    end
    r.zmp_lat = m_flt_lat[31:0];
    r.zmp_fwd = m_flt_fwd[31:0];
    r.tgt_lat = m_goal_lat[31:0];
    r.tgt_fwd = m_goal_fwd[31:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    balance_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", out_tuser, 0);
      else begin
        w = expected_q.pop_front();
        if (out_tuser !== w.status) report_mismatch("status", out_tuser, w.status);
        if (out_tdata[31:0] !== w.angle) report_mismatch("angle_step", out_tdata[31:0], w.angle);
        if (out_tdata[63:32] !== w.shift) report_mismatch("shift_step", out_tdata[63:32], w.shift);
        if (out_tdata[95:64] !== w.zmp_lat)
          report_mismatch("zmp_lateral", out_tdata[95:64], w.zmp_lat);
        if (out_tdata[127:96] !== w.zmp_fwd)
          report_mismatch("zmp_forward", out_tdata[127:96], w.zmp_fwd);
        if (out_tdata[159:128] !== w.tgt_lat)
          report_mismatch("target_lateral", out_tdata[159:128], w.tgt_lat);
        if (out_tdata[191:160] !== w.tgt_fwd)
          report_mismatch("target_forward", out_tdata[191:160], w.tgt_fwd);
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (!quiet_tail && rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SENSOR_HEIGHT: m_height = val[23:0];
      REG_EMA_ALPHA:     m_alpha = val[15:0];
      REG_ANGLE_GAIN:    m_gain = val[23:0];
      REG_ANGLE_LIMIT:   m_angle_lim = val[29:0];
      REG_SHIFT_LIMIT:   m_shift_lim = val[29:0];
      REG_TARGET_OFFSET: m_offset = val[23:0];
      REG_SAMPLE_LIMIT:  m_window = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // send one request, with an optional idle burst first
  task automatic send_request(input logic signed [31:0] fx, fy, fz, ty, tz,
                              input logic leg);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[160:0] = {leg, tz, ty, fz, fy, fx};
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_step(d));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all results, then idle before the next step
  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      3: return -($urandom_range(0, 65535) << $urandom_range(0, 16));
      default: return $urandom;
    endcase
  endfunction

  // sensible stance sample with random content, sometimes zero force
  task automatic send_random;
    logic signed [31:0] fx;
    if ($urandom_range(0, 9) == 0) fx = rand_word();
    else if ($urandom_range(0, 19) == 0) fx = 0;
    else fx = $urandom_range(200, 800) << 16;
    if ($urandom_range(0, 1)) fx = -fx;
    if ($urandom_range(0, 7) == 0)
      send_request(fx, rand_word(), rand_word(), rand_word(), rand_word(),
                   1'($urandom));
    else
      send_request(fx, $signed($urandom_range(0, 40 << 16)) - (20 << 16),
                   $signed($urandom_range(0, 40 << 16)) - (20 << 16),
                   $signed($urandom_range(0, 20 << 16)) - (10 << 16),
                   $signed($urandom_range(0, 20 << 16)) - (10 << 16),
                   1'($urandom));
  endtask

  task automatic test_directed;
    send_request(0, 5 << 16, 5 << 16, 1 << 16, 1 << 16, 0);
    // origin point: zero numerators fix a zero target
    send_request(500 << 16, 0, 0, 0, 0, 0);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 1);
    send_request(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 0);
    send_request(-1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 1);
    send_request(32'sh8000_0000, -1, -1, -1, -1, 0);
    send_request(0, -1, -1, -1, -1, 1);
    send_request(400 << 16, 3 << 16, -2 << 16, 1 << 16, -1 << 16, 1);
    drain();
  endtask

  task automatic test_window_done;
    cfg_write(REG_SAMPLE_LIMIT, 3);
    repeat (6) send_random();
    drain();
    cfg_write(REG_SAMPLE_LIMIT, 0);
    repeat (3) send_random();
    drain();
  endtask

  task automatic test_config_sweep;
    logic [31:0] sets [4][7];
    sets[0] = '{0, 0, 0, 0, 0, 0, 65535};
    sets[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    sets[2] = '{419430, 45875, 468276, 1123850, 2147484, 503316, 65535};
    sets[3] = '{$urandom, $urandom, $urandom, $urandom_range(0, 1 << 24),
                $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 22), 65535};
    for (int s = 0; s < 4; s++) begin
      for (int r = 0; r < 7; r++) cfg_write(3'(r), sets[s][r]);
      repeat (60) send_random();
      drain();
    end
  endtask

  task automatic test_random_stream;
    cfg_write(REG_EMA_ALPHA, $urandom_range(1000, 65535));
    cfg_write(REG_SAMPLE_LIMIT, 450);
    for (int i = 0; i < 500; i++) begin
      send_random();
      // hold off until the block has returned every result
      if (i == 200) while (expected_q.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  task automatic test_quiet_tail;
    quiet_tail = 1;
    cfg_write(REG_SAMPLE_LIMIT, 40);
    repeat (50) send_random();
    drain();
  endtask

  initial begin
    m_height = RST_SENSOR_HEIGHT;
    m_alpha = RST_EMA_ALPHA;
    m_gain = RST_ANGLE_GAIN;
    m_angle_lim = RST_ANGLE_LIMIT;
    m_shift_lim = RST_SHIFT_LIMIT;
    m_offset = RST_TARGET_OFFSET;
    m_window = RST_SAMPLE_LIMIT;
    m_flt_lat = 0;
    m_flt_fwd = 0;
    m_goal_lat = 0;
    m_goal_fwd = 0;
    m_goal_set = 0;
    m_seen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_done();
    test_config_sweep();
    test_random_stream();
    test_quiet_tail();
    if (errors == 0) $display("zmp_balance_controller_top_tb: clean");
    else $display("zmp_balance_controller_top_tb: errors");
    $finish;
  end

endmodule
